// ----- hdl/tmap_pkg.sv -----
// shared constants for the square-root tone mapper
// no dependencies
package tmap_pkg;
	localparam int FIELD_BITS = 32;
	localparam int COUNT_BITS_DEF = 32;
	localparam int LEVEL_BITS = 8;
	localparam int LEVEL_STAGES = 8;
	localparam int PADDR_BITS = 4;
	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 8'd255;
	localparam logic [LEVEL_BITS-1:0] ALPHA = 8'd255;
	// register indexes on the configuration port
	localparam logic [1:0] REG_RED_PEAK = 2'd0;
	localparam logic [1:0] REG_GREEN_PEAK = 2'd1;
	localparam logic [1:0] REG_BLUE_PEAK = 2'd2;
endpackage

// ----- hdl/tmap_if.sv -----
// pixel stream interfaces: hit counts in, packed bgra word out
// depends on tmap_pkg
interface tmap_in_if;
	logic valid;
	logic ready;
	logic [tmap_pkg::FIELD_BITS-1:0] red_count;
	logic [tmap_pkg::FIELD_BITS-1:0] green_count;
	logic [tmap_pkg::FIELD_BITS-1:0] blue_count;
	modport source (output valid, red_count, green_count, blue_count, input ready);
	modport sink (input valid, red_count, green_count, blue_count, output ready);
endinterface

interface tmap_out_if;
	logic valid;
	logic ready;
	logic [tmap_pkg::FIELD_BITS-1:0] packed_pixel;
	modport source (output valid, packed_pixel, input ready);
	modport sink (input valid, packed_pixel, output ready);
endinterface

// ----- hdl/tmap_level.sv -----
// one channel: exact floor(255*sqrt(count/peak)) as a 9-stage pipeline
// one prep stage, then one result bit per stage by shift-and-add; depends on tmap_pkg
module tmap_level #(
	parameter int COUNT_BITS = tmap_pkg::COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic en,
	input  logic [tmap_pkg::FIELD_BITS-1:0] count,
	input  logic [tmap_pkg::FIELD_BITS-1:0] peak,
	output logic [tmap_pkg::LEVEL_BITS-1:0] level
);
	localparam int W = COUNT_BITS + 16;
	localparam int KPW = COUNT_BITS + 8;
	localparam int N = tmap_pkg::LEVEL_STAGES;

	logic [COUNT_BITS-1:0] cnt;
	logic [COUNT_BITS-1:0] pk;
	assign cnt = count[COUNT_BITS-1:0];
	assign pk = peak[COUNT_BITS-1:0];

	logic [W-1:0] tgt_s [0:N];
	logic [COUNT_BITS-1:0] peak_s [0:N];
	logic zero_s [0:N];
	logic sat_s [0:N];
	logic [W-1:0] kp2_s [0:N];
	logic [KPW-1:0] kp_s [0:N];
	logic [tmap_pkg::LEVEL_BITS-1:0] k_s [0:N];

	// prep stage: 65025*count = (c<<16) - (c<<9) + c, special cases flagged
	always_ff @(posedge clk) begin
		if (en) begin
			tgt_s[0] <= (W'(cnt) << 16) - (W'(cnt) << 9) + W'(cnt);
			peak_s[0] <= pk;
			zero_s[0] <= (pk == '0);
			sat_s[0] <= (cnt >= pk);
			kp2_s[0] <= '0;
			kp_s[0] <= '0;
			k_s[0] <= '0;
		end
	end

	// bit stages: (k+2^b)^2*peak = k^2*peak + (k*peak)<<(b+1) + peak<<2b
	for (genvar j = 0; j < N; j++) begin : g_bit
		localparam int B = N - 1 - j;
		logic [W-1:0] trial;
		logic take;
		assign trial = kp2_s[j] + (W'(kp_s[j]) << (B + 1)) + (W'(peak_s[j]) << (2 * B));
		assign take = (trial <= tgt_s[j]);
		always_ff @(posedge clk) begin
			if (en) begin
				tgt_s[j+1] <= tgt_s[j];
				peak_s[j+1] <= peak_s[j];
				zero_s[j+1] <= zero_s[j];
				sat_s[j+1] <= sat_s[j];
				kp2_s[j+1] <= take ? trial : kp2_s[j];
				kp_s[j+1] <= take ? (kp_s[j] + (KPW'(peak_s[j]) << B)) : kp_s[j];
				k_s[j+1] <= take ? (k_s[j] | (tmap_pkg::LEVEL_BITS'(1) << B)) : k_s[j];
			end
		end
	end

	// final select
	always_comb begin
		if (zero_s[N]) level = '0;
		else if (sat_s[N]) level = tmap_pkg::LEVEL_MAX;
		else level = k_s[N];
	end
endmodule

// ----- hdl/sqrt_tone_map_rgb_to_bgra.sv -----
// top level: apb peak registers, three channel pipelines, valid chain, packing
// depends on tmap_pkg, tmap_if, tmap_level
//
// Square-root tone mapper. Each accepted pixel of red, green and blue hit
// counts yields one word {alpha 255, red, green, blue}, each level being
// floor(255*sqrt(count/peak)) computed exactly; a peak of zero gives 0 and a
// count at or above peak gives 255. One pixel is accepted every cycle unless
// the output stalls, which holds the whole pipeline; each passes a prep stage
// and one stage per result bit. The user must write peaks over the apb port at
// byte addresses 0, 4 and 8 only while the stream is idle; not enforced here.
module sqrt_tone_map_rgb_to_bgra #(
	parameter int COUNT_BITS = tmap_pkg::COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [tmap_pkg::PADDR_BITS-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	tmap_in_if.sink pix_in,
	tmap_out_if.source pix_out
);
	localparam int DEPTH = tmap_pkg::LEVEL_STAGES + 1;

	logic [31:0] red_peak_q, green_peak_q, blue_peak_q;
	logic [1:0] reg_idx;
	logic en;
	logic [DEPTH-1:0] valid_q;
	logic [tmap_pkg::LEVEL_BITS-1:0] r_lvl, g_lvl, b_lvl;

	assign reg_idx = paddr[3:2];
	assign pready = 1'b1;

	// peak registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_peak_q <= '0;
			green_peak_q <= '0;
			blue_peak_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				tmap_pkg::REG_RED_PEAK: red_peak_q <= pwdata;
				tmap_pkg::REG_GREEN_PEAK: green_peak_q <= pwdata;
				tmap_pkg::REG_BLUE_PEAK: blue_peak_q <= pwdata;
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (reg_idx)
			tmap_pkg::REG_RED_PEAK: prdata = red_peak_q;
			tmap_pkg::REG_GREEN_PEAK: prdata = green_peak_q;
			tmap_pkg::REG_BLUE_PEAK: prdata = blue_peak_q;
			default: prdata = '0;
		endcase
	end

	// pipeline advances unless the last stage holds a transaction not taken
	assign en = !valid_q[DEPTH-1] || pix_out.ready;
	assign pix_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[DEPTH-2:0], pix_in.valid};
		end
	end

	tmap_level #(.COUNT_BITS(COUNT_BITS)) u_red (
		.clk(clk), .en(en), .count(pix_in.red_count), .peak(red_peak_q), .level(r_lvl)
	);
	tmap_level #(.COUNT_BITS(COUNT_BITS)) u_green (
		.clk(clk), .en(en), .count(pix_in.green_count), .peak(green_peak_q), .level(g_lvl)
	);
	tmap_level #(.COUNT_BITS(COUNT_BITS)) u_blue (
		.clk(clk), .en(en), .count(pix_in.blue_count), .peak(blue_peak_q), .level(b_lvl)
	);

	// output packing
	assign pix_out.valid = valid_q[DEPTH-1];
	assign pix_out.packed_pixel = {tmap_pkg::ALPHA, r_lvl, g_lvl, b_lvl};
endmodule

// ----- sim/tmap_checker.sv -----
// checker for the square-root tone mapper: predicts and compares packed pixels
// depends on tmap_pkg and the stream interfaces in hdl/tmap_if.sv
module tmap_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic [31:0] red_peak,
	input  logic [31:0] green_peak,
	input  logic [31:0] blue_peak,
	tmap_in_if pix_in,
	tmap_out_if pix_out,
	output int error_count,
	output int pending_count,
	output int pixels_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] pixel_queue[$];

	// exact floor(255*sqrt(count/peak)) by bitwise search
	function automatic logic [7:0] tone_level(logic [31:0] count, logic [31:0] peak);
		logic [7:0] k;
		logic [7:0] trial;
		logic [63:0] target;
		logic [63:0] prod;
		k = 8'd0;
		if (peak == 32'd0)
			return 8'd0;
		if (count >= peak)
			return tmap_pkg::LEVEL_MAX;
		target = 64'd65025 * {32'd0, count};
		for (int b = 7; b >= 0; b--) begin
			trial = k | (8'd1 << b);
			prod = {56'd0, trial} * {56'd0, trial} * {32'd0, peak};
			if (prod <= target)
				k = trial;
		end
		return k;
	endfunction

	function automatic logic [31:0] tone_map_pixel(logic [31:0] r, logic [31:0] g,
			logic [31:0] b);
		return {tmap_pkg::ALPHA, tone_level(r, red_peak), tone_level(g, green_peak),
			tone_level(b, blue_peak)};
	endfunction

	assign pending_count = pixel_queue.size();

	// predict on each input transaction, compare on each output transaction
	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			error_count <= 0;
			pixels_checked <= 0;
		end else begin
			if (pix_out.valid && pix_out.ready) begin
				if (pixel_queue.size() == 0) begin
					error_count <= error_count + 1;
					if (error_count < 10)
						$display("unexpected output transaction %h", pix_out.packed_pixel);
				end else begin
					want = pixel_queue.pop_front();
					pixels_checked <= pixels_checked + 1;
					if (want !== pix_out.packed_pixel) begin
						error_count <= error_count + 1;
						if (error_count < 10)
							$display("packed_pixel mismatch: expected %h actual %h",
								want, pix_out.packed_pixel);
					end
				end
			end
			if (pix_in.valid && pix_in.ready)
				pixel_queue.push_back(tone_map_pixel(pix_in.red_count,
					pix_in.green_count, pix_in.blue_count));
		end
	end
endmodule

// ----- sim/tb.sv -----
// top of the tone mapper testbench: clock, reset, apb peak writes, pixel stimulus
// depends on tmap_pkg, hdl/tmap_if.sv, the block and sim/tmap_checker.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [tmap_pkg::PADDR_BITS-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic [31:0] red_peak;
	logic [31:0] green_peak;
	logic [31:0] blue_peak;
	int error_count;
	int pending_count;
	int pixels_checked;
	int idle_cycles;
	bit sink_calm;
	int pixels_sent;

	tmap_in_if pix_in ();
	tmap_out_if pix_out ();

	sqrt_tone_map_rgb_to_bgra i_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pix_in(pix_in), .pix_out(pix_out)
	);

	tmap_checker i_checker (
		.clk(clk), .arst_n(arst_n), .red_peak(red_peak), .green_peak(green_peak),
		.blue_peak(blue_peak), .pix_in(pix_in), .pix_out(pix_out),
		.error_count(error_count), .pending_count(pending_count),
		.pixels_checked(pixels_checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("DONE: errors detected");
			$finish;
		end
	end

	// output side: random stall bursts unless calm
	initial begin
		int gap;
		pix_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!sink_calm && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 13);
				pix_out.ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				pix_out.ready <= 1'b1;
			end
		end
	end

	task automatic peak_write(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			tmap_pkg::REG_RED_PEAK: red_peak = value;
			tmap_pkg::REG_GREEN_PEAK: green_peak = value;
			default: blue_peak = value;
		endcase
	endtask

	task automatic set_peaks(logic [31:0] r, logic [31:0] g, logic [31:0] b);
		peak_write(tmap_pkg::REG_RED_PEAK, r);
		peak_write(tmap_pkg::REG_GREEN_PEAK, g);
		peak_write(tmap_pkg::REG_BLUE_PEAK, b);
	endtask

	// one pixel transaction, optional idle burst first
	task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b, bit gaps);
		if (gaps && $urandom_range(0, 7) == 0) begin
			pix_in.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.red_count <= r;
		pix_in.green_count <= g;
		pix_in.blue_count <= b;
		@(posedge clk);
		while (!pix_in.ready) @(posedge clk);
		pixels_sent++;
	endtask

	task automatic drain();
		pix_in.valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// random count near a peak, at or below it, small, or anywhere
	function automatic logic [31:0] rand_count(logic [31:0] peak);
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return peak == 0 ? $urandom_range(0, 3) : $urandom_range(0, peak);
			2: return peak + $urandom_range(0, 2) - 1;
			default: return $urandom_range(0, 1000);
		endcase
	endfunction

	function automatic logic [31:0] rand_peak();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(1, 300);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] pr, pg, pb;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		red_peak = 32'd0;
		green_peak = 32'd0;
		blue_peak = 32'd0;
		pix_in.valid = 1'b0;
		pix_in.red_count = '0;
		pix_in.green_count = '0;
		pix_in.blue_count = '0;
		sink_calm = 1'b0;
		pixels_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero peaks after reset give zero levels
		send_pixel(32'd0, 32'hFFFF_FFFF, 32'd5, 1'b0);
		drain();
		// directed: a full-scale red peak, extremes and near-peak counts
		set_peaks(32'hFFFF_FFFF, 32'd1, 32'd1000);
		send_pixel(32'd0, 32'd0, 32'd0, 1'b0);
		send_pixel(32'hFFFF_FFFF, 32'd1, 32'd1000, 1'b0);
		send_pixel(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd999, 1'b0);
		send_pixel(32'd1, 32'd2, 32'd1, 1'b0);
		send_pixel(32'h8000_0000, 32'd0, 32'd250, 1'b0);
		send_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'd1001, 1'b0);
		drain();
		set_peaks(32'd0, 32'hFFFF_FFFF, 32'd65025);
		send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd1, 1'b0);
		send_pixel(32'd7, 32'h0000_0001, 32'd65024, 1'b0);
		send_pixel(32'hAAAA_AAAA, 32'h5555_5555, 32'd256, 1'b0);
		drain();

		// random phases with new peaks; calm last phase
		for (int phase = 0; phase < 16; phase++) begin
			if (phase == 15)
				sink_calm = 1'b1;
			pr = rand_peak();
			pg = rand_peak();
			pb = rand_peak();
			set_peaks(pr, pg, pb);
			for (int n = 0; n < 100; n++)
				send_pixel(rand_count(pr), rand_count(pg), rand_count(pb), phase != 15);
			drain();
		end

		$display("sent %0d pixels over 19 peak settings, %0d results checked",
			pixels_sent, pixels_checked);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ----- files.f -----
hdl/tmap_pkg.sv
hdl/tmap_if.sv
hdl/tmap_level.sv
hdl/sqrt_tone_map_rgb_to_bgra.sv
sim/tmap_checker.sv
sim/tb.sv
